// ===== rtl/core/ujse_pkg.sv =====
// Shared types, character constants and helper functions for the UTF-8
// validating JSON string escaper. No dependencies; used by every core module.

package ujse_pkg;

   // Characters that appear in the escaped text
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CONTROL_LIMIT = 8'h20;

   // UTF-8 lead byte ranges
   localparam logic [7:0] LEAD2_LOW  = 8'hC2;
   localparam logic [7:0] LEAD2_HIGH = 8'hDF;
   localparam logic [7:0] LEAD3_LOW  = 8'hE0;
   localparam logic [7:0] LEAD3_HIGH = 8'hEF;
   localparam logic [7:0] LEAD4_LOW  = 8'hF0;
   localparam logic [7:0] LEAD4_HIGH = 8'hF4;

   // Code point limits
   localparam logic [20:0] MIN_TWO_BYTE   = 21'h00080;
   localparam logic [20:0] MIN_THREE_BYTE = 21'h00800;
   localparam logic [20:0] MIN_FOUR_BYTE  = 21'h10000;
   localparam logic [20:0] SURROGATE_LOW  = 21'h0D800;
   localparam logic [20:0] SURROGATE_HIGH = 21'h0DFFF;
   localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;

   // How the byte of an item is written out
   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_PLAIN,
      BODY_ESCAPE,
      BODY_UNICODE
   } ujse_body_type;

   // One accepted item, ready to be expanded into result bytes
   typedef struct packed {
      logic          open_quote;
      ujse_body_type body;
      logic [7:0]    data;
      logic          close_quote;
      logic          invalid;
      logic [3:0]    count;
   } ujse_item_type;

   // One result byte with its flags
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_string;
      logic       invalid_utf8;
   } ujse_result_type;

   // Serializer status toward the input handshake
   typedef struct packed {
      logic valid;
      logic final_step;
   } ujse_ser_status_type;

   function automatic logic [3:0] body_length(input ujse_body_type body);
      logic [3:0] len;
      case (body)
         BODY_NONE:    len = 4'd0;
         BODY_PLAIN:   len = 4'd1;
         BODY_ESCAPE:  len = 4'd2;
         BODY_UNICODE: len = 4'd6;
         default:      len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] ch;
      if (nibble < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, nibble};
      end else begin
         ch = CHAR_LOWER_A + {4'd0, nibble} - 8'd10;
      end
      return ch;
   endfunction

   // Byte at position pos of the item's escaped body
   function automatic logic [7:0] body_byte(input ujse_item_type item, input logic [3:0] pos);
      logic [7:0] ch;
      case (item.body)
         BODY_PLAIN: ch = item.data;
         BODY_ESCAPE: ch = (pos == 4'd0) ? CHAR_BSLASH : item.data;
         BODY_UNICODE: begin
            case (pos)
               4'd0:    ch = CHAR_BSLASH;
               4'd1:    ch = CHAR_U;
               4'd4:    ch = hex_char(item.data[7:4]);
               4'd5:    ch = hex_char(item.data[3:0]);
               default: ch = CHAR_ZERO;
            endcase
         end
         default: ch = item.data;
      endcase
      return ch;
   endfunction

   // Result at position idx of the item's output run
   function automatic ujse_result_type result_at(input ujse_item_type item,
                                                 input logic [2:0] idx);
      ujse_result_type res;
      logic [3:0] pos;
      pos = {1'b0, idx} - {3'd0, item.open_quote};
      res.last_of_run = ({1'b0, idx} == item.count - 4'd1);
      res.end_of_string = 1'b0;
      res.invalid_utf8 = 1'b0;
      if (item.open_quote && idx == 3'd0) begin
         res.out_byte = CHAR_QUOTE;
      end else if (pos < body_length(item.body)) begin
         res.out_byte = body_byte(item, pos);
      end else begin
         res.out_byte = CHAR_QUOTE;
         res.end_of_string = 1'b1;
         res.invalid_utf8 = item.invalid;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/ujse_utf8_check.sv =====
// UTF-8 validation state for the JSON string escaper: decodes each accepted
// byte and keeps the sticky error flag. Depends on ujse_pkg.

module ujse_utf8_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       first_of_string,
   input  logic       last_of_string,
   input  logic       empty_string,
   output logic       invalid_utf8
);

   logic [1:0]  pending_ff, pending_in;
   logic [1:0]  seq_len_ff, seq_len_in;
   logic [20:0] acc_ff, acc_in;
   logic        error_ff, error_in;
   logic [20:0] acc_shift;

   // Decode the byte against the state left by the previous item
   always_comb begin
      pending_in = first_of_string ? 2'd0 : pending_ff;
      seq_len_in = first_of_string ? 2'd0 : seq_len_ff;
      acc_in     = first_of_string ? 21'd0 : acc_ff;
      error_in   = first_of_string ? 1'b0 : error_ff;
      acc_shift  = {acc_in[14:0], data_byte[5:0]};
      invalid_utf8 = 1'b0;

      if (!empty_string) begin
         if (pending_in == 2'd0) begin
            if (data_byte[7] == 1'b0) begin
               // plain ASCII, nothing to track
            end else if (data_byte >= ujse_pkg::LEAD2_LOW && data_byte <= ujse_pkg::LEAD2_HIGH) begin
               pending_in = 2'd1;
               seq_len_in = 2'd1;
               acc_in = {16'd0, data_byte[4:0]};
            end else if (data_byte >= ujse_pkg::LEAD3_LOW && data_byte <= ujse_pkg::LEAD3_HIGH) begin
               pending_in = 2'd2;
               seq_len_in = 2'd2;
               acc_in = {17'd0, data_byte[3:0]};
            end else if (data_byte >= ujse_pkg::LEAD4_LOW && data_byte <= ujse_pkg::LEAD4_HIGH) begin
               pending_in = 2'd3;
               seq_len_in = 2'd3;
               acc_in = {18'd0, data_byte[2:0]};
            end else begin
               error_in = 1'b1;
            end
         end else if (data_byte[7:6] != 2'b10) begin
            // drop the pending sequence
            error_in = 1'b1;
            pending_in = 2'd0;
            seq_len_in = 2'd0;
            acc_in = 21'd0;
         end else begin
            pending_in = pending_in - 2'd1;
            if (pending_in == 2'd0) begin
               if ((seq_len_in == 2'd1 && acc_shift < ujse_pkg::MIN_TWO_BYTE) ||
                   (seq_len_in == 2'd2 && acc_shift < ujse_pkg::MIN_THREE_BYTE) ||
                   (seq_len_in == 2'd3 && acc_shift < ujse_pkg::MIN_FOUR_BYTE) ||
                   (acc_shift >= ujse_pkg::SURROGATE_LOW &&
                    acc_shift <= ujse_pkg::SURROGATE_HIGH) ||
                   acc_shift > ujse_pkg::MAX_CODE_POINT) begin
                  error_in = 1'b1;
               end
               seq_len_in = 2'd0;
               acc_in = 21'd0;
            end else begin
               acc_in = acc_shift;
            end
         end
      end

      // Close the string: flag any earlier error or a cut-off sequence, then clear
      if (last_of_string) begin
         invalid_utf8 = error_in | (pending_in != 2'd0);
         pending_in = 2'd0;
         seq_len_in = 2'd0;
         acc_in = 21'd0;
         error_in = 1'b0;
      end
   end

   // Advance the state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         seq_len_ff <= 2'd0;
         acc_ff <= 21'd0;
         error_ff <= 1'b0;
      end else if (accept) begin
         pending_ff <= pending_in;
         seq_len_ff <= seq_len_in;
         acc_ff <= acc_in;
         error_ff <= error_in;
      end
   end

endmodule

// ===== rtl/core/ujse_serializer.sv =====
// Holding register and step counter that expand one item into its run of
// escaped result bytes, one per step. Depends on ujse_pkg.

module ujse_serializer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  ujse_pkg::ujse_item_type       item,
   input  logic                          advance,
   output ujse_pkg::ujse_ser_status_type status,
   output ujse_pkg::ujse_result_type     result
);

   ujse_pkg::ujse_item_type hold_ff;
   logic                    valid_ff;
   logic [2:0]              idx_ff;

   // Pick the current byte of the run
   always_comb begin
      result = ujse_pkg::result_at(hold_ff, idx_ff);
      status.valid = valid_ff;
      status.final_step = result.last_of_run;
   end

   // Hold the item payload
   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= item;
      end
   end

   // Step through the run; a new item overrides a finished one
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff <= 3'd0;
      end else if (valid_ff && advance) begin
         if (result.last_of_run) begin
            valid_ff <= 1'b0;
            idx_ff <= 3'd0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

endmodule

// ===== rtl/core/utf8_validating_json_string_escaper_core.sv =====
// Top level of the UTF-8 validating JSON string escaper: input handshake,
// result register and assertions. Depends on ujse_pkg, ujse_utf8_check and
// ujse_serializer.
//
// Each input item carries one string byte and emits that byte as quoted JSON
// text, one result byte per cycle unless rsp_tready stalls: the opening quote
// on the first item, the byte itself (backslash-escaped for quote and
// backslash, \u00xx for control bytes), and the closing quote on the last
// item, which also reports in invalid_utf8 whether the string held bad UTF-8.
// An item whose run is one byte is taken every cycle unless rsp_tready stalls;
// a longer run holds the input while the serializer steps one byte per open
// cycle into the result register. The next item is accepted in the cycle its
// predecessor's final byte moves to the result register: no bubble between runs.

module utf8_validating_json_string_escaper_core (
   input  logic       clock,
   input  logic       reset,
   // input items
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_of_string
   input  logic [1:0] req_tuser,   // [0] first_of_string, [1] empty_string
   // result items
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_of_run
   output logic [1:0] rsp_tuser    // [0] end_of_string, [1] invalid_utf8
);

   logic                          req_accept;
   logic                          out_open;
   logic                          load;
   logic                          invalid_utf8;
   ujse_pkg::ujse_item_type       item;
   ujse_pkg::ujse_ser_status_type ser_status;
   ujse_pkg::ujse_result_type     ser_result;
   logic                          rsp_valid_ff;
   ujse_pkg::ujse_result_type     rsp_data_ff;

   // Result register can take a byte this cycle
   assign out_open = !rsp_valid_ff || rsp_tready;

   // Take an item when no run is held, or once the held run is on its final byte and moving out
   assign req_tready = !ser_status.valid || (ser_status.final_step && out_open);
   assign req_accept = req_tvalid && req_tready;

   ujse_utf8_check u_check (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .data_byte       (req_tdata),
      .first_of_string (req_tuser[0]),
      .last_of_string  (req_tlast),
      .empty_string    (req_tuser[1]),
      .invalid_utf8    (invalid_utf8)
   );

   // Classify the byte and size its run
   always_comb begin
      item.open_quote = req_tuser[0];
      item.close_quote = req_tlast;
      item.data = req_tdata;
      item.invalid = invalid_utf8;
      if (req_tuser[1]) begin
         item.body = ujse_pkg::BODY_NONE;
      end else if (req_tdata == ujse_pkg::CHAR_QUOTE || req_tdata == ujse_pkg::CHAR_BSLASH) begin
         item.body = ujse_pkg::BODY_ESCAPE;
      end else if (req_tdata < ujse_pkg::CONTROL_LIMIT) begin
         item.body = ujse_pkg::BODY_UNICODE;
      end else begin
         item.body = ujse_pkg::BODY_PLAIN;
      end
      item.count = {3'd0, item.open_quote} + ujse_pkg::body_length(item.body)
                   + {3'd0, item.close_quote};
   end

   // Items with no output run are dropped after updating validation
   assign load = req_accept && (item.count != 4'd0);

   ujse_serializer u_serializer (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .item    (item),
      .advance (out_open),
      .status  (ser_status),
      .result  (ser_result)
   );

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= ser_status.valid;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (out_open && ser_status.valid) begin
         rsp_data_ff <= ser_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff.out_byte;
   assign rsp_tlast = rsp_data_ff.last_of_run;
   assign rsp_tuser = {rsp_data_ff.invalid_utf8, rsp_data_ff.end_of_string};

   // The closing quote always ends its item's run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tdata == ujse_pkg::CHAR_QUOTE)
      else $error("closing quote not last of run or not a quote");

   // The error flag appears only on the closing quote
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("invalid_utf8 set outside closing quote");

   // A loaded item is held by the serializer in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      load |=> ser_status.valid)
      else $error("loaded item lost");

   // An item is never accepted while a run still has bytes besides the current one
   assert property (@(posedge clock) disable iff (reset)
      ser_status.valid && !ser_status.final_step |-> !req_accept)
      else $error("item accepted during an unfinished run");

endmodule
